[sv/prq_pkg.sv]
// Shared types and constants for the priority ready queue
package prq_pkg;

    localparam int ID_W              = 8;
    localparam int PRIO_W            = 6;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int MAX_PRIORITY_DEF  = 63;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_POP    = 2'd1,
        ACT_AGE    = 2'd2,
        ACT_CHECK  = 2'd3
    } t_action;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_slot;

    typedef struct packed {
        logic              en;
        t_action           action;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_cmd;

endpackage

[sv/priority_ready_queue_with_aging_unit.sv]
// Priority ready queue with aging: top level with cell chain and result register
// A request's result is registered and shows on the outputs in the cycle after it is accepted.
// Throughput: one request per cycle while the result is taken; an accepted insert,
// pop or age updates all cells together, but an insert into a full queue changes none.
// Reset: synchronous, active low; empties the queue and clears the result valid flag.
module priority_ready_queue_with_aging_unit #(
    parameter int QUEUE_DEPTH  = prq_pkg::QUEUE_DEPTH_DEF,
    parameter int MAX_PRIORITY = prq_pkg::MAX_PRIORITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_action,
    input  logic [prq_pkg::ID_W-1:0]   i_thread_id,
    input  logic [prq_pkg::PRIO_W-1:0] i_priority_req,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_popped_valid,
    output logic [prq_pkg::ID_W-1:0]   o_popped_id,
    output logic [prq_pkg::PRIO_W-1:0] o_popped_priority,
    output logic                       o_queue_empty,
    output logic                       o_preempt,
    output logic                       o_overflow
);
    import prq_pkg::*;

    localparam int PrioMax = (1 << PRIO_W) - 1;
    localparam logic [PRIO_W-1:0] PrioCap =
        PRIO_W'((MAX_PRIORITY > PrioMax) ? PrioMax : MAX_PRIORITY);

    t_slot             w_slot [QUEUE_DEPTH];
    logic              w_keep [QUEUE_DEPTH];
    t_cmd              w_cmd;
    t_action           w_action;
    logic              w_accept;
    logic              w_full;
    logic [PRIO_W-1:0] w_ins_prio;

    logic              r_out_valid;
    logic              r_popped_valid;
    logic [ID_W-1:0]   r_popped_id;
    logic [PRIO_W-1:0] r_popped_priority;
    logic              r_queue_empty;
    logic              r_preempt;
    logic              r_overflow;

    assign w_action   = t_action'(i_action);
    assign o_stall    = r_out_valid && i_stall;
    assign w_accept   = i_valid && !o_stall;
    assign w_full     = w_slot[QUEUE_DEPTH-1].valid;
    assign w_ins_prio = (i_priority_req > PrioCap) ? PrioCap : i_priority_req;

    always_comb begin
        w_cmd.en     = w_accept && !((w_action == ACT_INSERT) && w_full);
        w_cmd.action = w_action;
        w_cmd.id     = i_thread_id;
        w_cmd.prio   = (w_action == ACT_INSERT) ? w_ins_prio : i_priority_req;
    end

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_keep;

        if (k == 0) begin : g_head
            assign w_left      = '0;
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left      = w_slot[k-1];
            assign w_left_keep = w_keep[k-1];
        end

        if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_slot[k+1];
        end

        prq_cell #(
            .PRIO_CAP (PrioCap)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_slot      (w_slot[k]),
            .o_keep      (w_keep[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped_valid    <= 1'b0;
            r_popped_id       <= '0;
            r_popped_priority <= '0;
            r_preempt         <= 1'b0;
            r_overflow        <= 1'b0;
            r_queue_empty     <= !w_slot[0].valid;
            case (w_action)
                ACT_INSERT: begin
                    r_overflow    <= w_full;
                    r_queue_empty <= 1'b0;
                end
                ACT_POP: begin
                    if (w_slot[0].valid) begin
                        r_popped_valid    <= 1'b1;
                        r_popped_id       <= w_slot[0].id;
                        r_popped_priority <= w_slot[0].prio;
                        r_queue_empty     <= !w_slot[1].valid;
                    end
                end
                ACT_CHECK: begin
                    r_preempt <= w_slot[0].valid && (w_slot[0].prio > i_priority_req);
                end
                default: r_preempt <= 1'b0;
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_popped_valid    = r_popped_valid;
    assign o_popped_id       = r_popped_id;
    assign o_popped_priority = r_popped_priority;
    assign o_queue_empty     = r_queue_empty;
    assign o_preempt         = r_preempt;
    assign o_overflow        = r_overflow;

endmodule

[sv/prq_cell.sv]
// One queue cell: holds an entry and shifts, inserts or ages with its neighbours
module prq_cell #(
    parameter logic [prq_pkg::PRIO_W-1:0] PRIO_CAP = '1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  prq_pkg::t_cmd  i_cmd,
    input  prq_pkg::t_slot i_left,
    input  logic           i_left_keep,
    input  prq_pkg::t_slot i_right,
    output prq_pkg::t_slot o_slot,
    output logic           o_keep
);
    import prq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    assign o_slot = r_slot;
    assign o_keep = r_slot.valid && (r_slot.prio >= i_cmd.prio);

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.en) begin
            case (i_cmd.action)
                ACT_INSERT: begin
                    if (!o_keep) begin
                        if (i_left_keep) begin
                            n_slot = '{valid: 1'b1, id: i_cmd.id, prio: i_cmd.prio};
                        end else begin
                            n_slot = i_left;
                        end
                    end
                end
                ACT_POP: n_slot = i_right;
                ACT_AGE: begin
                    if (r_slot.valid && (r_slot.prio < PRIO_CAP)) begin
                        n_slot.prio = r_slot.prio + PRIO_W'(1);
                    end
                end
                default: n_slot = r_slot;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.id   <= n_slot.id;
        r_slot.prio <= n_slot.prio;
    end

endmodule

[sv/prq_checker.sv]
// Port-level assertions for the priority ready queue, bound to the top level
module prq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic                       o_popped_valid,
    input logic [prq_pkg::ID_W-1:0]   o_popped_id,
    input logic                       o_queue_empty,
    input logic                       o_preempt,
    input logic                       o_overflow
);
    import prq_pkg::*;

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted request gave no result");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_popped_id)
                                  && $stable(o_queue_empty)))
        else $error("stalled result changed");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones({o_popped_valid, o_preempt, o_overflow}) <= 1))
        else $error("more than one action flag in a result");

    a_overflow_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> !o_queue_empty)
        else $error("overflow reported with an empty queue");

endmodule

bind priority_ready_queue_with_aging_unit prq_checker u_prq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_popped_valid (o_popped_valid),
    .o_popped_id    (o_popped_id),
    .o_queue_empty  (o_queue_empty),
    .o_preempt      (o_preempt),
    .o_overflow     (o_overflow)
);
